// ===== src/sha_pkg.sv =====
// Shared types and constants for the SHA-256 digest block.
// Used by sha_front, sha_queue, sha_core and the top level; no dependencies.
package sha_pkg;

    // word queue between the packing front end and the compression core
    localparam int QDEPTH = 16;
    localparam int QAW    = $clog2(QDEPTH);

    // one queued message-schedule word plus block tags
    typedef struct packed {
        logic [31:0] word;
        logic        last_blk;   // 16th word of the message's final block
        logic        too_long;   // message length overflowed 2^61 bytes
    } t_qword;

    // round constants
    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // initial hash values
    localparam logic [31:0] IV_TABLE [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

// ===== src/sha_front.sv =====
// Front end: accepts byte transactions, packs them big-endian into 32-bit
// words, counts the message length and generates the padding words.
// Depends on sha_pkg.
module sha_front import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_push,
    output t_qword      o_push_data,
    input  logic        i_full
);

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_PAD  = 3'd1;
    localparam logic [2:0] F_ZERO = 3'd2;
    localparam logic [2:0] F_LHI  = 3'd3;
    localparam logic [2:0] F_LLO  = 3'd4;

    localparam logic [3:0] WIDX_LEN_HI = 4'd14;

    logic [2:0]  r_state, n_state;
    logic [60:0] r_count, n_count;
    logic        r_ovf, n_ovf;
    logic [23:0] r_acc, n_acc;
    logic [3:0]  r_widx, n_widx;
    logic        w_accept;
    logic [31:0] w_pad_word;

    assign o_in_stall = (r_state != F_IDLE) || i_full;
    assign w_accept   = i_in_valid && !o_in_stall;

    // partial word with the 0x80 pad byte appended
    always_comb begin
        unique case (r_count[1:0])
            2'd0: w_pad_word = {PAD_BYTE, 24'h0};
            2'd1: w_pad_word = {r_acc[7:0], PAD_BYTE, 16'h0};
            2'd2: w_pad_word = {r_acc[15:0], PAD_BYTE, 8'h0};
            2'd3: w_pad_word = {r_acc[23:0], PAD_BYTE};
        endcase
    end

    // packing and padding sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_acc       = r_acc;
        n_widx      = r_widx;
        o_push      = 1'b0;
        o_push_data = '{word: 32'h0, last_blk: 1'b0, too_long: 1'b0};
        unique case (r_state)
            F_IDLE: begin
                if (w_accept && i_byte_present) begin
                    n_count = r_count + 61'd1;
                    if (r_count == {61{1'b1}}) begin
                        n_ovf = 1'b1;
                    end
                    if (r_count[1:0] == 2'd3) begin
                        o_push           = 1'b1;
                        o_push_data.word = {r_acc, i_data_byte};
                    end else begin
                        n_acc = {r_acc[15:0], i_data_byte};
                    end
                end
                if (w_accept && i_end_of_message) begin
                    n_state = F_PAD;
                end
            end
            F_PAD: begin
                if (!i_full) begin
                    o_push           = 1'b1;
                    o_push_data.word = w_pad_word;
                    n_widx           = r_count[5:2] + 4'd1;
                    n_state          = (r_count[5:2] == WIDX_LEN_HI - 4'd1) ? F_LHI : F_ZERO;
                end
            end
            F_ZERO: begin
                if (!i_full) begin
                    o_push = 1'b1;
                    n_widx = r_widx + 4'd1;
                    if (r_widx == WIDX_LEN_HI - 4'd1) begin
                        n_state = F_LHI;
                    end
                end
            end
            F_LHI: begin
                if (!i_full) begin
                    o_push           = 1'b1;
                    o_push_data.word = r_count[60:29];
                    n_state          = F_LLO;
                end
            end
            F_LLO: begin
                if (!i_full) begin
                    o_push               = 1'b1;
                    o_push_data.word     = {r_count[28:0], 3'b000};
                    o_push_data.last_blk = 1'b1;
                    o_push_data.too_long = r_ovf;
                    n_count              = '0;
                    n_ovf                = 1'b0;
                    n_state              = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    // byte accumulator and word position
    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_widx <= n_widx;
    end

endmodule

// ===== src/sha_queue.sv =====
// Short word queue between the front end and the compression core.
// Depends on sha_pkg.
module sha_queue import sha_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_qword i_push_data,
    output logic   o_full,
    input  logic   i_pop,
    output t_qword o_head,
    output logic   o_empty
);

    t_qword             r_mem [QDEPTH];
    logic [QAW-1:0]     r_wr;
    logic [QAW-1:0]     r_rd;
    logic [QAW:0]       r_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(w_push) - (QAW+1)'(w_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

// ===== src/sha_core.sv =====
// Back end: 64-round SHA-256 compression, one round per cycle while queue words are
// at hand, with a rolling 16-word schedule window; holds the chain value and emits the digest.
// Depends on sha_pkg.
module sha_core import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_qword      i_head,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word,
    output logic        o_too_long
);

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_ROUND = 2'd1;
    localparam logic [1:0] B_ADD   = 2'd2;
    localparam logic [1:0] B_OUT   = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [31:0] r_chain [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [5:0]  r_t;
    logic        r_last;
    logic        r_toolong;
    logic [2:0]  r_oidx;

    logic        w_need;
    logic        w_step;
    logic        w_out_take;
    logic [31:0] w_sched;
    logic [31:0] w_wt;
    logic [31:0] w_t1;
    logic [31:0] w_t2;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    // rounds 0..15 take words from the queue, later rounds expand the window
    assign w_need  = (r_t[5:4] == 2'b00);
    assign w_sched = (rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10))
                   + r_w[9]
                   + (rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3))
                   + r_w[0];
    assign w_wt    = w_need ? i_head.word : w_sched;
    assign w_step  = (r_state == B_ROUND) && (!w_need || !i_empty);
    assign o_pop   = w_step && w_need;

    // round function
    assign w_t1 = r_v[7]
                + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
                + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                + K_TABLE[r_t] + w_wt;
    assign w_t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
                + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    // digest output straight from the chain registers
    assign o_out_valid   = (r_state == B_OUT);
    assign o_digest_word = r_toolong ? 32'h0 : r_chain[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'd7);
    assign o_too_long    = r_toolong;
    assign w_out_take    = o_out_valid && !i_out_stall;

    // state sequence
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:  if (!i_empty) n_state = B_ROUND;
            B_ROUND: if (w_step && r_t == 6'd63) n_state = B_ADD;
            B_ADD:   n_state = r_last ? B_OUT : B_IDLE;
            B_OUT:   if (w_out_take && o_last_word) n_state = B_IDLE;
        endcase
    end

    // control and chain value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_t       <= '0;
            r_oidx    <= '0;
            r_last    <= 1'b0;
            r_toolong <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= IV_TABLE[i];
            end
        end else begin
            r_state <= n_state;
            unique case (r_state)
                B_IDLE: begin
                    r_t    <= '0;
                    r_oidx <= '0;
                end
                B_ROUND: begin
                    if (w_step) begin
                        r_t <= r_t + 6'd1;
                    end
                    if (o_pop && r_t == 6'd15) begin
                        r_last    <= i_head.last_blk;
                        r_toolong <= i_head.too_long;
                    end
                end
                B_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_chain[i] <= r_chain[i] + r_v[i];
                    end
                end
                B_OUT: begin
                    if (w_out_take) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (o_last_word) begin
                            r_last    <= 1'b0;
                            r_toolong <= 1'b0;
                            for (int i = 0; i < 8; i++) begin
                                r_chain[i] <= IV_TABLE[i];
                            end
                        end
                    end
                end
            endcase
        end
    end

    // working variables and schedule window
    always_ff @(posedge i_clk) begin
        if (r_state == B_IDLE) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_chain[i];
            end
        end else if (w_step) begin
            r_v[0] <= w_t1 + w_t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + w_t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_wt;
        end
    end

endmodule

// ===== src/sha256_message_digest.sv =====
// SHA-256 digest: one byte transaction per cycle while packing, unless the queue is
// full; the core handles a 64-byte block as load, 64 rounds and chain add, overlapped
// with packing of the next block through a 16-word queue.
// An end transaction stalls input while the padding words are pushed (longer while the
// queue is full); the digest words are output after the chain add of the last block,
// which may be an extra block of zero words and the length. Sync active-low reset loads IV.
module sha256_message_digest import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word,
    output logic        o_too_long
);

    logic   w_push;
    t_qword w_push_data;
    logic   w_full;
    logic   w_pop;
    t_qword w_head;
    logic   w_empty;

    sha_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_data_byte      (i_data_byte),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .o_push           (w_push),
        .o_push_data      (w_push_data),
        .i_full           (w_full)
    );

    sha_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_empty     (w_empty)
    );

    sha_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word),
        .o_too_long    (o_too_long)
    );

    // front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full))
        else $error("word pushed into full queue");

    // a taken last word ends the digest burst
    a_burst_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_word) |=> !o_out_valid)
        else $error("output valid after last digest word");

    // overlong messages report zero words
    a_too_long_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_too_long) |-> (o_digest_word == 32'h0))
        else $error("nonzero digest word on overlong message");

endmodule
